### rtl/rcsg_pkg.sv
package rcsg_pkg;

  localparam int unsigned MaxStones = 256;
  localparam int unsigned CoordBits = 16;
  localparam int unsigned IdxBits   = $clog2(MaxStones);
  localparam int unsigned CntBits   = $clog2(MaxStones + 1);
  localparam int unsigned OutBits   = 9;

  typedef struct packed {
    logic [15:0] stone_row;
    logic [15:0] stone_col;
    logic        last_stone;
  } stone_in_t;

  typedef struct packed {
    logic [8:0] removable_count;
    logic [8:0] group_total;
    logic       overflow;
  } group_out_t;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StScan  = 4'b0010,
    StMerge = 4'b0100,
    StDone  = 4'b1000
  } rcsg_state_e;

endpackage

### rtl/row_column_stone_grouping.sv
// stone grouping for the most-stones-removed problem. one stone is accepted per
// input beat; on the beat marked last_stone one result beat gives the stone count
// minus the number of row/column connected groups, the group count, and an overflow
// flag if stones beyond capacity (MaxStones) were dropped. stones live in a single
// synchronous memory (row, column, label) with a registered read port. a new stone
// with index n takes one scan over entries 0..n-1; each stored stone that shares a
// row or column with it and is not yet in its group starts a relabel sweep over
// entries 0..n-1. ready stays low from acceptance through the scan, every sweep and
// the done state, with at most one memory read per cycle. a dropped stone goes
// straight from idle to the done state; the flush after the last stone also waits
// while an earlier result beat is still held in the output register. no clearing
// pass is needed: entries at or above the stone count are never read.
module row_column_stone_grouping (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  rcsg_pkg::stone_in_t     in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output rcsg_pkg::group_out_t    out_data_o
);
  import rcsg_pkg::*;

  localparam int unsigned EntBits = 2 * CoordBits + IdxBits;

  // stone memory: {row, col, label}
  logic [EntBits-1:0] mem_q [MaxStones];
  logic [EntBits-1:0] rd_q;
  logic               mem_we;
  logic [IdxBits-1:0] mem_wa;
  logic [EntBits-1:0] mem_wd;
  logic [IdxBits-1:0] mem_ra;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= mem_q[mem_ra];
  end

  rcsg_state_e        state_q, state_d;
  logic [CntBits-1:0] stone_cnt_q, stone_cnt_d;
  logic [CntBits-1:0] group_cnt_q, group_cnt_d;
  logic               ovf_q, ovf_d;
  logic [CoordBits-1:0] row_q, row_d, col_q, col_d;
  logic               last_q, last_d;
  logic [CntBits-1:0] scan_q, scan_d;   // scan position (address issued)
  logic [CntBits-1:0] sweep_q, sweep_d; // relabel sweep address issued
  logic               rdv_q, rdv_d;     // rd_q holds entry at addr_q
  logic [IdxBits-1:0] addr_q, addr_d;
  logic [IdxBits-1:0] from_q, from_d;
  logic               out_valid_q, out_valid_d;
  group_out_t         out_q, out_d;

  logic [IdxBits-1:0] new_idx;
  logic [CoordBits-1:0] rd_row, rd_col;
  logic [IdxBits-1:0] rd_lab;
  logic [CntBits-1:0] grp_fin;

  assign new_idx = stone_cnt_q[IdxBits-1:0];
  assign rd_row  = rd_q[EntBits-1 -: CoordBits];
  assign rd_col  = rd_q[IdxBits +: CoordBits];
  assign rd_lab  = rd_q[IdxBits-1:0];
  assign grp_fin = group_cnt_q;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    stone_cnt_d = stone_cnt_q;
    group_cnt_d = group_cnt_q;
    ovf_d       = ovf_q;
    row_d       = row_q;
    col_d       = col_q;
    last_d      = last_q;
    scan_d      = scan_q;
    sweep_d     = sweep_q;
    rdv_d       = 1'b0;
    addr_d      = addr_q;
    from_d      = from_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_wa      = new_idx;
    mem_wd      = {row_q, col_q, new_idx};
    mem_ra      = addr_q;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          row_d  = in_data_i.stone_row[CoordBits-1:0];
          col_d  = in_data_i.stone_col[CoordBits-1:0];
          last_d = in_data_i.last_stone;
          if (stone_cnt_q == CntBits'(MaxStones)) begin
            ovf_d   = 1'b1;
            state_d = StDone;
          end else begin
            mem_we  = 1'b1;
            mem_wd  = {in_data_i.stone_row[CoordBits-1:0],
                       in_data_i.stone_col[CoordBits-1:0], new_idx};
            group_cnt_d = group_cnt_q + CntBits'(1);
            scan_d  = '0;
            state_d = StScan;
          end
        end
      end
      StScan: begin
        // pipeline: issue read at scan_q, evaluate previous read
        if (rdv_q && (rd_row == row_q || rd_col == col_q) && rd_lab != new_idx) begin
          from_d      = rd_lab;
          group_cnt_d = group_cnt_q - CntBits'(1);
          sweep_d     = '0;
          state_d     = StMerge;
        end else if (scan_q == stone_cnt_q) begin
          stone_cnt_d = stone_cnt_q + CntBits'(1);
          state_d     = StDone;
        end else begin
          mem_ra = scan_q[IdxBits-1:0];
          addr_d = scan_q[IdxBits-1:0];
          rdv_d  = 1'b1;
          scan_d = scan_q + CntBits'(1);
        end
      end
      StMerge: begin
        // relabel sweep over 0..n-1; read at sweep_q, write back previous
        if (rdv_q && rd_lab == from_q) begin
          mem_we = 1'b1;
          mem_wa = addr_q;
          mem_wd = {rd_row, rd_col, new_idx};
        end
        if (sweep_q == stone_cnt_q) begin
          // resume scan at the entry after the one that triggered the merge
          state_d = StScan;
        end else begin
          mem_ra  = sweep_q[IdxBits-1:0];
          addr_d  = sweep_q[IdxBits-1:0];
          rdv_d   = 1'b1;
          sweep_d = sweep_q + CntBits'(1);
          if (rdv_q && rd_lab == from_q && addr_q == sweep_q[IdxBits-1:0]) begin
            rdv_d = 1'b1;
          end
        end
      end
      StDone: begin
        if (!last_q) begin
          state_d = StIdle;
        end else if (!out_valid_q || out_ready_i) begin
          out_valid_d           = 1'b1;
          out_d.removable_count = OutBits'(stone_cnt_q - grp_fin);
          out_d.group_total     = OutBits'(grp_fin);
          out_d.overflow        = ovf_q;
          stone_cnt_d = '0;
          group_cnt_d = '0;
          ovf_d       = 1'b0;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      stone_cnt_q <= '0;
      group_cnt_q <= '0;
      ovf_q       <= 1'b0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
      scan_q      <= '0;
      sweep_q     <= '0;
    end else begin
      state_q     <= state_d;
      stone_cnt_q <= stone_cnt_d;
      group_cnt_q <= group_cnt_d;
      ovf_q       <= ovf_d;
      rdv_q       <= rdv_d;
      out_valid_q <= out_valid_d;
      scan_q      <= scan_d;
      sweep_q     <= sweep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    col_q  <= col_d;
    last_q <= last_d;
    addr_q <= addr_d;
    from_q <= from_d;
    out_q  <= out_d;
  end

endmodule
